// ===== rtl/assert_macros.svh =====
// Assertion helpers shared by the RTL files.
`ifndef ASSERT_MACROS_SVH
`define ASSERT_MACROS_SVH

// Check on every rising edge outside reset.
`define ASSERT_CLK(lbl, prop, msg) \
  lbl: assert property (@(posedge clk_i) disable iff (!rst_ni) prop) else $error(msg);

// Check on every rising edge, reset included.
`define ASSERT_ALWAYS(lbl, prop, msg) \
  lbl: assert property (@(posedge clk_i) prop) else $error(msg);

`endif

// ===== rtl/utf8s_pkg.sv =====
`default_nettype none

package utf8s_pkg;

  // Byte classification masks and patterns
  localparam logic [7:0] AsciiMask  = 8'h80;
  localparam logic [7:0] Lead2Mask  = 8'hE0;
  localparam logic [7:0] Lead2Patt  = 8'hC0;
  localparam logic [7:0] Lead3Mask  = 8'hF0;
  localparam logic [7:0] Lead3Patt  = 8'hE0;
  localparam logic [7:0] Lead4Mask  = 8'hF8;
  localparam logic [7:0] Lead4Patt  = 8'hF0;
  localparam logic [7:0] ContMask   = 8'hC0;
  localparam logic [7:0] ContPatt   = 8'h80;
  localparam logic [7:0] Over2Mask  = 8'h1E;
  localparam logic [7:0] SurrLead   = 8'hED;
  localparam logic [7:0] Over3Lead  = 8'hE0;
  localparam logic [7:0] Bit5Mask   = 8'h20;
  localparam logic [7:0] Over4Lead  = 8'hF0;
  localparam logic [7:0] Over4Mask  = 8'h30;
  localparam logic [7:0] MaxLead    = 8'hF4;
  localparam logic [7:0] MaxSecond  = 8'h8F;

  // U+FFFD encoding
  localparam logic [7:0] Repl0 = 8'hEF;
  localparam logic [7:0] Repl1 = 8'hBF;
  localparam logic [7:0] Repl2 = 8'hBD;

  // Result group produced by one input word
  typedef struct packed {
    logic [3:0][7:0] data;   // data[0] goes out first
    logic [2:0]      cnt;    // 0..4 words
    logic            repl;   // whole group is a replacement character
    logic            last;   // group closes the string
  } grp_t;

endpackage

`default_nettype wire

// ===== rtl/utf8s_core.sv =====
`default_nettype none

`include "assert_macros.svh"

module utf8s_core (
  input  wire logic            clk_i,
  input  wire logic            rst_ni,
  input  wire logic            s_tvalid_i,
  output logic                 s_tready_o,
  input  wire logic [7:0]      s_tdata_i,
  input  wire logic            s_tlast_i,
  input  wire logic            grp_ready_i,
  output logic                 grp_load_o,
  output utf8s_pkg::grp_t      grp_o
);
  import utf8s_pkg::*;

  logic            in_valid_q;
  logic [7:0]      in_byte_q;
  logic            in_last_q;
  logic [2:0]      exp_q, exp_d;
  logic [1:0]      cnt_q, cnt_d;
  logic [2:0][7:0] pend_q;
  logic [2:0]      pend_we;
  logic [3:0][7:0] seq;
  logic [2:0]      lead_n;
  logic            adv;
  logic            complete;
  grp_t            grp;

  function automatic logic seq_ok(input logic [3:0][7:0] s, input logic [2:0] n);
    logic ok;
    ok = 1'b1;
    if (n >= 3'd2 && (s[1] & ContMask) != ContPatt) ok = 1'b0;
    if (n >= 3'd3 && (s[2] & ContMask) != ContPatt) ok = 1'b0;
    if (n == 3'd4 && (s[3] & ContMask) != ContPatt) ok = 1'b0;
    unique case (n)
      3'd2: if ((s[0] & Over2Mask) == 8'h00) ok = 1'b0;
      3'd3: begin
        if (s[0] == SurrLead && (s[1] & Bit5Mask) == Bit5Mask) ok = 1'b0;
        if (s[0] == Over3Lead && (s[1] & Bit5Mask) == 8'h00) ok = 1'b0;
      end
      3'd4: begin
        if (s[0] > MaxLead) ok = 1'b0;
        if (s[0] == Over4Lead && (s[1] & Over4Mask) == 8'h00) ok = 1'b0;
        if (s[0] == MaxLead && s[1] > MaxSecond) ok = 1'b0;
      end
      default: ok = 1'b0;
    endcase
    return ok;
  endfunction

  assign adv        = in_valid_q && grp_ready_i;
  assign s_tready_o = !in_valid_q || adv;

  // Assemble the complete sequence: held bytes then the current one
  always_comb begin
    seq[0] = pend_q[0];
    seq[1] = (cnt_q == 2'd1) ? in_byte_q : pend_q[1];
    seq[2] = (cnt_q == 2'd2) ? in_byte_q : pend_q[2];
    seq[3] = in_byte_q;
  end

  assign complete = (({1'b0, cnt_q} + 3'd1) >= exp_q) || (cnt_q == 2'd3);

  always_comb begin
    exp_d     = exp_q;
    cnt_d     = cnt_q;
    pend_we   = 3'b000;
    lead_n    = 3'd0;
    grp.data  = '0;
    grp.cnt   = 3'd0;
    grp.repl  = 1'b0;
    grp.last  = in_last_q;
    if (exp_q == 3'd0) begin
      priority if ((in_byte_q & AsciiMask) == 8'h00) begin
        grp.data[0] = in_byte_q;
        grp.cnt     = 3'd1;
      end else if ((in_byte_q & Lead2Mask) == Lead2Patt) begin
        lead_n = 3'd2;
      end else if ((in_byte_q & Lead3Mask) == Lead3Patt) begin
        lead_n = 3'd3;
      end else if ((in_byte_q & Lead4Mask) == Lead4Patt) begin
        lead_n = 3'd4;
      end else begin
        grp.repl = 1'b1;
      end
      if (lead_n != 3'd0) begin
        if (in_last_q) begin
          grp.repl = 1'b1;
        end else begin
          pend_we[0] = 1'b1;
          cnt_d      = 2'd1;
          exp_d      = lead_n;
        end
      end
    end else if (complete) begin
      if (seq_ok(seq, exp_q)) begin
        grp.data = seq;
        grp.cnt  = exp_q;
      end else begin
        grp.repl = 1'b1;
      end
      exp_d = 3'd0;
      cnt_d = 2'd0;
    end else begin
      // hold the byte and wait for the rest of the sequence
      pend_we[0] = (cnt_q == 2'd0);
      pend_we[1] = (cnt_q == 2'd1);
      pend_we[2] = (cnt_q == 2'd2);
      cnt_d      = cnt_q + 2'd1;
      if (in_last_q) begin
        grp.repl = 1'b1;
        exp_d    = 3'd0;
        cnt_d    = 2'd0;
      end
    end
    if (grp.repl) begin
      grp.data = {8'h00, Repl2, Repl1, Repl0};
      grp.cnt  = 3'd3;
    end
  end

  assign grp_o      = grp;
  assign grp_load_o = adv && (grp.cnt != 3'd0);

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      in_valid_q <= 1'b0;
      exp_q      <= 3'd0;
      cnt_q      <= 2'd0;
    end else begin
      if (s_tready_o) begin
        in_valid_q <= s_tvalid_i;
      end
      if (adv) begin
        exp_q <= exp_d;
        cnt_q <= cnt_d;
      end
    end
  end

  always_ff @(posedge clk_i) begin
    if (s_tready_o && s_tvalid_i) begin
      in_byte_q <= s_tdata_i;
      in_last_q <= s_tlast_i;
    end
    for (int i = 0; i < 3; i++) begin
      if (adv && pend_we[i]) begin
        pend_q[i] <= in_byte_q;
      end
    end
  end

  `ASSERT_ALWAYS(a_idle_empty, (exp_q == 3'd0) |-> (cnt_q == 2'd0), "count without open sequence")
  `ASSERT_CLK(a_open_short, (exp_q != 3'd0) |-> ((cnt_q != 2'd0) && ({1'b0, cnt_q} < exp_q)), "held count out of range")

endmodule

`default_nettype wire

// ===== rtl/utf8s_serial.sv =====
`default_nettype none

`include "assert_macros.svh"

module utf8s_serial (
  input  wire logic            clk_i,
  input  wire logic            rst_ni,
  input  wire logic            grp_load_i,
  input  utf8s_pkg::grp_t      grp_i,
  output logic                 grp_ready_o,
  output logic                 m_tvalid_o,
  input  wire logic            m_tready_i,
  output logic [7:0]           m_tdata_o,
  output logic                 m_tlast_o,
  output logic [1:0]           m_tuser_o
);
  import utf8s_pkg::*;

  grp_t       grp_q;
  logic       grp_valid_q;
  logic [1:0] idx_q;
  logic       at_end;
  logic       take;

  assign at_end      = (({1'b0, idx_q} + 3'd1) == grp_q.cnt);
  assign take        = grp_valid_q && m_tready_i;
  assign grp_ready_o = !grp_valid_q || (m_tready_i && at_end);

  assign m_tvalid_o = grp_valid_q;
  assign m_tdata_o  = grp_q.data[idx_q];
  assign m_tlast_o  = at_end && grp_q.last;
  assign m_tuser_o  = {grp_q.repl, at_end};

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      grp_valid_q <= 1'b0;
      idx_q       <= 2'd0;
    end else begin
      if (grp_load_i) begin
        grp_valid_q <= 1'b1;
        idx_q       <= 2'd0;
      end else if (take && at_end) begin
        grp_valid_q <= 1'b0;
      end else if (take) begin
        idx_q <= idx_q + 2'd1;
      end
    end
  end

  always_ff @(posedge clk_i) begin
    if (grp_load_i) begin
      grp_q <= grp_i;
    end
  end

  `ASSERT_CLK(a_load_free, grp_load_i |-> grp_ready_o, "group overwritten before drained")
  `ASSERT_CLK(a_idx_range, grp_valid_q |-> (({1'b0, idx_q} < grp_q.cnt) && (grp_q.cnt <= 3'd4)), "word index beyond group")

endmodule

`default_nettype wire

// ===== rtl/utf8_sanitizer.sv =====
`default_nettype none

// Channel   Dir  Handshake               Payload
// s_axis    in   tvalid/tready           tdata = in_byte, tlast = in_last
// m_axis    out  tvalid/tready           tdata = out_byte, tlast = string_last,
//                                        tuser = {was_replaced, run_last}
//
// An input word is registered, classified and, when it completes a sequence,
// checked; a non-empty group of up to 4 output words is loaded into the result
// register once it is free and drained one word per cycle while m_axis is ready.
// Sustained rate: one input word per cycle while each word yields at most one
// output word and m_axis is ready; a group of more words holds the input side
// until its last word is taken.
// Reset is asynchronous, active low, and leaves no sequence open.
// A stall on m_axis holds the result register and, once it is due to stay
// full, the input register and s_axis tready.

module utf8_sanitizer (
  input  wire logic       clk_i,
  input  wire logic       rst_ni,
  input  wire logic       s_axis_tvalid_i,
  output logic            s_axis_tready_o,
  input  wire logic [7:0] s_axis_tdata_i,   // [7:0] in_byte
  input  wire logic       s_axis_tlast_i,
  output logic            m_axis_tvalid_o,
  input  wire logic       m_axis_tready_i,
  output logic [7:0]      m_axis_tdata_o,   // [7:0] out_byte
  output logic            m_axis_tlast_o,
  output logic [1:0]      m_axis_tuser_o    // [0] run_last, [1] was_replaced
);
  import utf8s_pkg::*;

  grp_t grp;
  logic grp_load;
  logic grp_ready;

  // Decode and sequence tracking
  utf8s_core u_core (
    .clk_i       (clk_i),
    .rst_ni      (rst_ni),
    .s_tvalid_i  (s_axis_tvalid_i),
    .s_tready_o  (s_axis_tready_o),
    .s_tdata_i   (s_axis_tdata_i),
    .s_tlast_i   (s_axis_tlast_i),
    .grp_ready_i (grp_ready),
    .grp_load_o  (grp_load),
    .grp_o       (grp)
  );

  // Result register: drain one word per handshake
  utf8s_serial u_serial (
    .clk_i       (clk_i),
    .rst_ni      (rst_ni),
    .grp_load_i  (grp_load),
    .grp_i       (grp),
    .grp_ready_o (grp_ready),
    .m_tvalid_o  (m_axis_tvalid_o),
    .m_tready_i  (m_axis_tready_i),
    .m_tdata_o   (m_axis_tdata_o),
    .m_tlast_o   (m_axis_tlast_o),
    .m_tuser_o   (m_axis_tuser_o)
  );

endmodule

`default_nettype wire

// ===== bench/tb_top.sv =====
`default_nettype none

module tb_top;
  import utf8s_pkg::*;

  localparam int StallLimit = 2000;  // cycles without any handshake
  localparam int DrainWait  = 8;     // extra cycles once nothing is due

  typedef struct packed {
    logic [7:0] data;
    logic       run_last;
    logic       str_last;
    logic       repl;
  } out_word_t;

  logic       clk_i;
  logic       rst_ni;
  logic       s_axis_tvalid_i;
  logic       s_axis_tready_o;
  logic [7:0] s_axis_tdata_i;   // [7:0] in_byte
  logic       s_axis_tlast_i;
  logic       m_axis_tvalid_o;
  logic       m_axis_tready_i;
  logic [7:0] m_axis_tdata_o;   // [7:0] out_byte
  logic       m_axis_tlast_o;
  logic [1:0] m_axis_tuser_o;   // [0] run_last, [1] was_replaced

  // Sanitiser state as the predictor sees it
  logic [2:0]      seq_len;
  logic [1:0]      seq_held;
  logic [2:0][7:0] seq_bytes;

  out_word_t  due_words[$];
  logic [7:0] str_q[$];
  int         mismatch_cnt;
  int         words_sent;
  int         quiet_cycles;
  bit         idle_on;
  int         ready_left;

  utf8_sanitizer dut (
    .clk_i           (clk_i),
    .rst_ni          (rst_ni),
    .s_axis_tvalid_i (s_axis_tvalid_i),
    .s_axis_tready_o (s_axis_tready_o),
    .s_axis_tdata_i  (s_axis_tdata_i),
    .s_axis_tlast_i  (s_axis_tlast_i),
    .m_axis_tvalid_o (m_axis_tvalid_o),
    .m_axis_tready_i (m_axis_tready_i),
    .m_axis_tdata_o  (m_axis_tdata_o),
    .m_axis_tlast_o  (m_axis_tlast_o),
    .m_axis_tuser_o  (m_axis_tuser_o)
  );

  initial begin
    clk_i = 1'b0;
    forever #1 clk_i = ~clk_i;
  end

  // Mostly no gap or a short one, now and then a long one
  function automatic int pick_gap();
    int r;
    r = $urandom_range(0, 99);
    if (!idle_on || r < 50) return 0;
    if (r < 90) return $urandom_range(1, 3);
    return $urandom_range(8, 30);
  endfunction

  function automatic bit seq_ok(input logic [3:0][7:0] s, input int n);
    int j;
    for (j = 1; j < n; j++) begin
      if ((s[j] & ContMask) != ContPatt) return 1'b0;
    end
    case (n)
      2: begin
        if ((s[0] & Over2Mask) == 8'h00) return 1'b0;
      end
      3: begin
        if (s[0] == SurrLead && (s[1] & Bit5Mask) != 8'h00) return 1'b0;
        if (s[0] == Over3Lead && (s[1] & Bit5Mask) == 8'h00) return 1'b0;
      end
      4: begin
        if (s[0] > MaxLead) return 1'b0;
        if (s[0] == Over4Lead && (s[1] & Over4Mask) == 8'h00) return 1'b0;
        if (s[0] == MaxLead && s[1] > MaxSecond) return 1'b0;
      end
      default: return 1'b0;
    endcase
    return 1'b1;
  endfunction

  // Work out the output words one accepted input word causes and queue them
  task automatic sanitise_word(input logic [7:0] b, input logic is_last);
    logic [3:0][7:0] emit;
    logic [3:0][7:0] seq;
    out_word_t       w;
    int              k;
    int              j;
    bit              repl;
    k    = 0;
    repl = 1'b0;
    seq  = '0;
    emit = '0;
    if (seq_len == 3'd0) begin
      if ((b & AsciiMask) == 8'h00) begin
        emit[0] = b;
        k = 1;
      end else if ((b & Lead2Mask) == Lead2Patt || (b & Lead3Mask) == Lead3Patt ||
                   (b & Lead4Mask) == Lead4Patt) begin
        // A lead on the final word cannot open a sequence
        if (is_last) begin
          repl = 1'b1;
        end else begin
          seq_bytes[0] = b;
          seq_held     = 2'd1;
          seq_len      = ((b & Lead2Mask) == Lead2Patt) ? 3'd2 :
                         ((b & Lead3Mask) == Lead3Patt) ? 3'd3 : 3'd4;
        end
      end else begin
        repl = 1'b1;
      end
    end else if (int'(seq_held) + 1 >= int'(seq_len)) begin
      // Sequence complete: check it as a whole
      for (j = 0; j < int'(seq_held); j++) seq[j] = seq_bytes[j];
      seq[seq_held] = b;
      if (seq_ok(seq, int'(seq_len))) begin
        emit = seq;
        k    = int'(seq_len);
      end else begin
        repl = 1'b1;
      end
      seq_len  = 3'd0;
      seq_held = 2'd0;
    end else begin
      seq_bytes[seq_held] = b;
      seq_held = seq_held + 2'd1;
      if (is_last) begin
        repl     = 1'b1;
        seq_len  = 3'd0;
        seq_held = 2'd0;
      end
    end
    if (repl) begin
      emit[0] = Repl0;
      emit[1] = Repl1;
      emit[2] = Repl2;
      k = 3;
    end
    for (j = 0; j < k; j++) begin
      w.data     = emit[j];
      w.run_last = (j == k - 1);
      w.str_last = (j == k - 1) && is_last;
      w.repl     = repl;
      due_words.push_back(w);
    end
  endtask

  // Offer one word after an optional gap and hold it until taken.
  // Starts and ends on a falling edge.
  task automatic send_word(input logic [7:0] b, input logic is_last);
    int gap;
    gap = pick_gap();
    if (gap > 0) begin
      s_axis_tvalid_i <= 1'b0;
      repeat (gap) @(negedge clk_i);
    end
    s_axis_tvalid_i <= 1'b1;
    s_axis_tdata_i  <= b;
    s_axis_tlast_i  <= is_last;
    do @(posedge clk_i); while (!s_axis_tready_o);
    sanitise_word(b, is_last);
    words_sent++;
    @(negedge clk_i);
  endtask

  task automatic send_string();
    int j;
    for (j = 0; j < str_q.size(); j++) send_word(str_q[j], j == str_q.size() - 1);
  endtask

  function automatic logic [7:0] cont_byte();
    return 8'h80 | 8'($urandom_range(0, 63));
  endfunction

  function automatic logic [7:0] lead_for(input int n);
    case (n)
      2:       return 8'($urandom_range(8'hC2, 8'hDF));
      3:       return 8'($urandom_range(8'hE0, 8'hEF));
      default: return 8'($urandom_range(8'hF0, 8'hF4));
    endcase
  endfunction

  // Append one piece of text to str_q: mostly well formed, some rejected,
  // broken or cut short
  task automatic add_piece();
    int         r;
    int         n;
    int         j;
    int         bad;
    int         have;
    logic [7:0] lead;
    r    = $urandom_range(0, 99);
    n    = $urandom_range(2, 4);
    have = 0;
    if (r < 37) begin
      str_q.push_back(8'($urandom_range(0, 127)));
    end else if (r < 40) begin
      str_q.push_back(8'($urandom_range(0, 255)));
    end else if (r < 75) begin
      lead = lead_for(n);
      str_q.push_back(lead);
      if (lead == Over3Lead)       str_q.push_back(8'hA0 | 8'($urandom_range(0, 31)));
      else if (lead == SurrLead)   str_q.push_back(8'h80 | 8'($urandom_range(0, 31)));
      else if (lead == Over4Lead)  str_q.push_back(8'($urandom_range(8'h90, 8'hBF)));
      else if (lead == MaxLead)    str_q.push_back(8'h80 | 8'($urandom_range(0, 15)));
      else                         str_q.push_back(cont_byte());
      for (j = 2; j < n; j++) str_q.push_back(cont_byte());
    end else if (r < 85) begin
      // Overlong, surrogate or beyond the code space, padded to full length
      case ($urandom_range(0, 5))
        0: begin
          str_q.push_back(8'($urandom_range(8'hC0, 8'hC1)));
          n    = 2;
          have = 1;
        end
        1: begin
          str_q.push_back(Over3Lead);
          str_q.push_back(8'h80 | 8'($urandom_range(0, 31)));
          n    = 3;
          have = 2;
        end
        2: begin
          str_q.push_back(SurrLead);
          str_q.push_back(8'hA0 | 8'($urandom_range(0, 31)));
          n    = 3;
          have = 2;
        end
        3: begin
          str_q.push_back(Over4Lead);
          str_q.push_back(8'h80 | 8'($urandom_range(0, 15)));
          n    = 4;
          have = 2;
        end
        4: begin
          str_q.push_back(MaxLead);
          str_q.push_back(8'($urandom_range(8'h90, 8'hBF)));
          n    = 4;
          have = 2;
        end
        default: begin
          str_q.push_back(8'($urandom_range(8'hF5, 8'hF7)));
          n    = 4;
          have = 1;
        end
      endcase
      for (j = have; j < n; j++) str_q.push_back(cont_byte());
    end else if (r < 93) begin
      // Right length, one trailing word replaced by anything
      bad = $urandom_range(1, n - 1);
      str_q.push_back(lead_for(n));
      for (j = 1; j < n; j++) begin
        str_q.push_back(j == bad ? 8'($urandom_range(0, 255)) : cont_byte());
      end
    end else begin
      // Cut short: whatever follows gets swallowed or the string ends
      str_q.push_back(lead_for(n));
      repeat ($urandom_range(0, n - 2)) str_q.push_back(cont_byte());
    end
  endtask

  task automatic test_directed_cases();
    logic [7:0] seqs[$];
    logic       lasts[$];
    int         j;
    // ASCII extremes, invalid leads, overlong, surrogate, too large, valid four
    // words, swallowed ASCII, sequence open at string end, lone lead at end
    seqs  = '{8'h00, 8'h7F, 8'h80, 8'hFF, 8'hC1, 8'hBF,
              8'hE0, 8'h9F, 8'h80, 8'hED, 8'hA0, 8'h80,
              8'hF4, 8'h90, 8'h80, 8'h80, 8'hF0, 8'h90, 8'h80, 8'h80,
              8'hC2, 8'h41, 8'hE2, 8'h82, 8'hF0};
    lasts = '{1'b0, 1'b1, 1'b0, 1'b0, 1'b0, 1'b0,
              1'b0, 1'b0, 1'b0, 1'b0, 1'b0, 1'b0,
              1'b0, 1'b0, 1'b0, 1'b0, 1'b0, 1'b0, 1'b0, 1'b0,
              1'b0, 1'b0, 1'b0, 1'b1, 1'b1};
    for (j = 0; j < seqs.size(); j++) send_word(seqs[j], lasts[j]);
  endtask

  task automatic test_mixed_strings(input int upto);
    while (words_sent < upto) begin
      str_q.delete();
      repeat ($urandom_range(1, 6)) add_piece();
      send_string();
    end
  endtask

  task automatic test_byte_noise(input int upto);
    while (words_sent < upto) begin
      str_q.delete();
      repeat ($urandom_range(1, 8)) str_q.push_back(8'($urandom_range(0, 255)));
      send_string();
    end
  endtask

  // Output side: random stalls while idling is on, otherwise always ready
  initial begin
    ready_left = 0;
    forever begin
      @(negedge clk_i);
      if (ready_left > 0) begin
        ready_left--;
      end else if (m_axis_tready_i && idle_on) begin
        ready_left = pick_gap();
        if (ready_left > 0) begin
          m_axis_tready_i <= 1'b0;
          ready_left--;
        end else begin
          ready_left = $urandom_range(0, 7);
        end
      end else begin
        m_axis_tready_i <= 1'b1;
        ready_left = $urandom_range(0, 7);
      end
    end
  end

  // Compare every accepted output word with the oldest one due
  always @(posedge clk_i) begin
    out_word_t got;
    out_word_t want;
    if (rst_ni && m_axis_tvalid_o && m_axis_tready_i) begin
      got.data     = m_axis_tdata_o;
      got.run_last = m_axis_tuser_o[0];
      got.str_last = m_axis_tlast_o;
      got.repl     = m_axis_tuser_o[1];
      if (due_words.size() == 0) begin
        mismatch_cnt++;
        $display("%0t: unexpected word data=%h run_last=%b str_last=%b repl=%b",
                 $time, got.data, got.run_last, got.str_last, got.repl);
      end else begin
        want = due_words.pop_front();
        if (got !== want) begin
          mismatch_cnt++;
          $display("%0t: mismatch expected data=%h run_last=%b str_last=%b repl=%b",
                   $time, want.data, want.run_last, want.str_last, want.repl);
          $display("%0t:          actual   data=%h run_last=%b str_last=%b repl=%b",
                   $time, got.data, got.run_last, got.str_last, got.repl);
        end
      end
    end
  end

  // Give up when neither side has moved a word for too long
  always @(posedge clk_i) begin
    if (!rst_ni || (s_axis_tvalid_i && s_axis_tready_o) ||
        (m_axis_tvalid_o && m_axis_tready_i)) begin
      quiet_cycles <= 0;
    end else if (quiet_cycles >= StallLimit) begin
      $display("tb_top: done, errors");
      $finish;
    end else begin
      quiet_cycles <= quiet_cycles + 1;
    end
  end

  initial begin
    rst_ni          = 1'b0;
    s_axis_tvalid_i = 1'b0;
    s_axis_tdata_i  = 8'h00;
    s_axis_tlast_i  = 1'b0;
    m_axis_tready_i = 1'b0;
    seq_len         = 3'd0;
    seq_held        = 2'd0;
    seq_bytes       = '0;
    mismatch_cnt    = 0;
    words_sent      = 0;
    quiet_cycles    = 0;
    idle_on         = 1'b1;
    repeat (7) @(negedge clk_i);
    rst_ni <= 1'b1;
    @(negedge clk_i);

    test_directed_cases();
    test_mixed_strings(words_sent + 170);
    test_byte_noise(words_sent + 60);
    idle_on = 1'b0;
    test_mixed_strings(words_sent + 55);
    s_axis_tvalid_i <= 1'b0;

    // Drain, then keep watching for any stray word
    while (due_words.size() != 0) @(posedge clk_i);
    repeat (DrainWait) @(posedge clk_i);
    if (mismatch_cnt == 0) begin
      $display("tb_top: done, clean");
    end else begin
      $display("tb_top: done, errors");
    end
    $finish;
  end

endmodule

`default_nettype wire

// ===== filelist.f =====
+incdir+rtl
rtl/utf8s_pkg.sv
rtl/utf8s_core.sv
rtl/utf8s_serial.sv
rtl/utf8_sanitizer.sv
bench/tb_top.sv
